### hw/rtl/fmprc_pkg.sv
// Shared types, field widths, mode codes and a prefix-mask helper for the rule classifier.
`default_nettype none

package fmprc_pkg;

    localparam int MODE_W     = 3;
    localparam int RULE_IDX_W = 4;
    localparam int SLOT_IDX_W = 2;
    localparam int CODE_W     = 8;
    localparam int ADDR_W     = 32;
    localparam int PREFIX_W   = 6;
    localparam int PORT_W     = 16;

    localparam logic [MODE_W-1:0] MODE_LOOKUP   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_WR_PROTO = 3'd1;
    localparam logic [MODE_W-1:0] MODE_WR_ADDR  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_WR_PORT  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SET_RULE = 3'd4;

    // Write command toward the rule table.
    typedef struct packed {
        logic                  en;
        logic [MODE_W-1:0]     mode;
        logic [RULE_IDX_W-1:0] rule_index;
        logic [SLOT_IDX_W-1:0] slot_index;
        logic                  entry_valid;
        logic [CODE_W-1:0]     code;
        logic [ADDR_W-1:0]     address;
        logic [ADDR_W-1:0]     mask;
        logic [PORT_W-1:0]     range_low;
        logic [PORT_W-1:0]     range_high;
    } t_wr_cmd;

    // Packet header fields searched against every rule.
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [ADDR_W-1:0] address;
        logic [PORT_W-1:0] port;
    } t_key;

    // Prefix length to network mask; anything at or above 32 is exact.
    function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PREFIX_W-1:0] plen);
        logic [ADDR_W-1:0] m;
        if (plen >= PREFIX_W'(ADDR_W)) begin
            m = '1;
        end else begin
            m = ~({ADDR_W{1'b1}} >> plen);
        end
        return m;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/fmprc_rule_table.sv
// Rule table storage with slot writes and a parallel match of all rules.
`default_nettype none

module fmprc_rule_table #(
    parameter int RULES           = 16,
    parameter int PROTOS_PER_RULE = 4,
    parameter int ADDRS_PER_RULE  = 4,
    parameter int PORTS_PER_RULE  = 4
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire fmprc_pkg::t_wr_cmd i_wr,
    input  wire fmprc_pkg::t_key    i_key,
    output logic [RULES-1:0]        o_match
);
    import fmprc_pkg::*;

    for (genvar r = 0; r < RULES; r++) begin : g_rule
        logic                   row_sel;
        logic                   r_rule_v;
        logic [PROTOS_PER_RULE-1:0] r_proto_v;
        logic [CODE_W-1:0]      r_proto_code [PROTOS_PER_RULE];
        logic [ADDRS_PER_RULE-1:0]  r_addr_v;
        logic [ADDR_W-1:0]      r_addr_net   [ADDRS_PER_RULE];
        logic [ADDR_W-1:0]      r_addr_mask  [ADDRS_PER_RULE];
        logic [PORTS_PER_RULE-1:0]  r_port_v;
        logic [PORT_W-1:0]      r_port_lo    [PORTS_PER_RULE];
        logic [PORT_W-1:0]      r_port_hi    [PORTS_PER_RULE];
        logic                   p_hit;
        logic                   a_hit;
        logic                   q_hit;

        // rows beyond the index range never compare equal
        assign row_sel = i_wr.en && (int'(i_wr.rule_index) == r);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_rule_v  <= 1'b0;
                r_proto_v <= '0;
                r_addr_v  <= '0;
                r_port_v  <= '0;
            end else if (row_sel) begin
                if (i_wr.mode == MODE_SET_RULE) begin
                    r_rule_v <= i_wr.entry_valid;
                end
                for (int s = 0; s < PROTOS_PER_RULE; s++) begin
                    if (i_wr.mode == MODE_WR_PROTO && int'(i_wr.slot_index) == s) begin
                        r_proto_v[s] <= i_wr.entry_valid;
                    end
                end
                for (int s = 0; s < ADDRS_PER_RULE; s++) begin
                    if (i_wr.mode == MODE_WR_ADDR && int'(i_wr.slot_index) == s) begin
                        r_addr_v[s] <= i_wr.entry_valid;
                    end
                end
                for (int s = 0; s < PORTS_PER_RULE; s++) begin
                    if (i_wr.mode == MODE_WR_PORT && int'(i_wr.slot_index) == s) begin
                        r_port_v[s] <= i_wr.entry_valid;
                    end
                end
            end
        end

        // slot contents, no reset
        always_ff @(posedge i_clk) begin
            if (row_sel) begin
                for (int s = 0; s < PROTOS_PER_RULE; s++) begin
                    if (i_wr.mode == MODE_WR_PROTO && int'(i_wr.slot_index) == s) begin
                        r_proto_code[s] <= i_wr.code;
                    end
                end
                for (int s = 0; s < ADDRS_PER_RULE; s++) begin
                    if (i_wr.mode == MODE_WR_ADDR && int'(i_wr.slot_index) == s) begin
                        r_addr_net[s]  <= i_wr.address;
                        r_addr_mask[s] <= i_wr.mask;
                    end
                end
                for (int s = 0; s < PORTS_PER_RULE; s++) begin
                    if (i_wr.mode == MODE_WR_PORT && int'(i_wr.slot_index) == s) begin
                        r_port_lo[s] <= i_wr.range_low;
                        r_port_hi[s] <= i_wr.range_high;
                    end
                end
            end
        end

        always_comb begin
            p_hit = 1'b0;
            for (int s = 0; s < PROTOS_PER_RULE; s++) begin
                if (r_proto_v[s] && r_proto_code[s] == i_key.code) begin
                    p_hit = 1'b1;
                end
            end
            a_hit = 1'b0;
            for (int s = 0; s < ADDRS_PER_RULE; s++) begin
                if (r_addr_v[s] && ((i_key.address ^ r_addr_net[s]) & r_addr_mask[s]) == '0)
                begin
                    a_hit = 1'b1;
                end
            end
            q_hit = 1'b0;
            for (int s = 0; s < PORTS_PER_RULE; s++) begin
                if (r_port_v[s] && i_key.port >= r_port_lo[s] && i_key.port <= r_port_hi[s])
                begin
                    q_hit = 1'b1;
                end
            end
        end

        assign o_match[r] = r_rule_v && p_hit && a_hit && q_hit;
    end

endmodule

`default_nettype wire

### hw/rtl/first_match_packet_rule_classifier_core.sv
// Top level of the first-match packet rule classifier: pipeline and winner select.
`default_nettype none

// Usage
//   Input channel (i_valid / o_stall) carries one beat per item: a lookup
//   (mode 0) or a table write (modes 1..4). Output channel (o_valid / i_stall)
//   carries one beat per lookup: o_hit and o_matched_rule (lowest matching
//   rule, 0 on a miss). Writes and unused modes give no output beat.
//   Throughput: one beat per cycle on both sides, no gaps between items, while i_stall is low.
//   Path: a lookup passes through the input register, the match vector
//   register and the output register before it drives o_valid.
//   Stage 1 does the parallel compare of every slot of every rule; writes
//   take effect as they leave stage 1, so items are applied strictly in
//   arrival order and a lookup sees every earlier write.
//   Stage 2 isolates the lowest set match bit and encodes it.
//   Stall: each stage holds when the one after it is full and blocked, so a
//   stalled output holds its beat and bubbles still close up; o_stall rises
//   only when all three stages are full.
//   Reset (i_rst_n low, synchronous) empties the pipe and clears every rule
//   and slot valid bit; the table is usable on the first cycle after reset.
module first_match_packet_rule_classifier_core #(
    parameter int RULES           = 16,
    parameter int PROTOS_PER_RULE = 4,
    parameter int ADDRS_PER_RULE  = 4,
    parameter int PORTS_PER_RULE  = 4
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    output logic                                  o_stall,
    input  wire logic [fmprc_pkg::MODE_W-1:0]     i_mode,
    input  wire logic [fmprc_pkg::RULE_IDX_W-1:0] i_rule_index,
    input  wire logic [fmprc_pkg::SLOT_IDX_W-1:0] i_slot_index,
    input  wire logic                             i_entry_valid,
    input  wire logic [fmprc_pkg::CODE_W-1:0]     i_protocol_code,
    input  wire logic [fmprc_pkg::ADDR_W-1:0]     i_entry_address,
    input  wire logic [fmprc_pkg::PREFIX_W-1:0]   i_entry_prefix,
    input  wire logic [fmprc_pkg::PORT_W-1:0]     i_range_low,
    input  wire logic [fmprc_pkg::PORT_W-1:0]     i_range_high,
    input  wire logic [fmprc_pkg::ADDR_W-1:0]     i_dst_address,
    input  wire logic [fmprc_pkg::PORT_W-1:0]     i_dest_port,
    output logic                                  o_valid,
    input  wire logic                             i_stall,
    output logic                                  o_hit,
    output logic [fmprc_pkg::RULE_IDX_W-1:0]      o_matched_rule
);
    import fmprc_pkg::*;

    // stage enables: a stage may load when empty or when it drains
    logic en_out;
    logic en_s2;
    logic en_s1;

    // stage 1: registered beat
    logic                  r_s1_v;
    logic [MODE_W-1:0]     r_s1_mode;
    logic [RULE_IDX_W-1:0] r_s1_rule_index;
    logic [SLOT_IDX_W-1:0] r_s1_slot_index;
    logic                  r_s1_entry_valid;
    logic [CODE_W-1:0]     r_s1_code;
    logic [ADDR_W-1:0]     r_s1_entry_address;
    logic [ADDR_W-1:0]     r_s1_mask;
    logic [PORT_W-1:0]     r_s1_range_low;
    logic [PORT_W-1:0]     r_s1_range_high;
    logic [ADDR_W-1:0]     r_s1_dst_address;
    logic [PORT_W-1:0]     r_s1_dest_port;

    t_wr_cmd               wr_cmd;
    t_key                  key;
    logic [RULES-1:0]      match_vec;

    // stage 2: per-rule match bits of a lookup
    logic                  r_s2_v;
    logic [RULES-1:0]      r_s2_match;
    logic [RULES-1:0]      first_bit;
    logic [RULE_IDX_W-1:0] n_rule;

    // output register
    logic                  r_o_v;
    logic                  r_o_hit;
    logic [RULE_IDX_W-1:0] r_o_rule;

    assign en_out  = !r_o_v || !i_stall;
    assign en_s2   = !r_s2_v || en_out;
    assign en_s1   = !r_s1_v || en_s2;
    assign o_stall = !en_s1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (en_s1) begin
            r_s1_v <= i_valid;
        end
    end

    // prefix mask is built on entry so the compare stage only ANDs
    always_ff @(posedge i_clk) begin
        if (en_s1 && i_valid) begin
            r_s1_mode          <= i_mode;
            r_s1_rule_index    <= i_rule_index;
            r_s1_slot_index    <= i_slot_index;
            r_s1_entry_valid   <= i_entry_valid;
            r_s1_code          <= i_protocol_code;
            r_s1_entry_address <= i_entry_address;
            r_s1_mask          <= prefix_mask(i_entry_prefix);
            r_s1_range_low     <= i_range_low;
            r_s1_range_high    <= i_range_high;
            r_s1_dst_address   <= i_dst_address;
            r_s1_dest_port     <= i_dest_port;
        end
    end

    // a write commits on the edge its beat leaves stage 1
    always_comb begin
        wr_cmd.en          = r_s1_v && en_s2 && (r_s1_mode != MODE_LOOKUP);
        wr_cmd.mode        = r_s1_mode;
        wr_cmd.rule_index  = r_s1_rule_index;
        wr_cmd.slot_index  = r_s1_slot_index;
        wr_cmd.entry_valid = r_s1_entry_valid;
        wr_cmd.code        = r_s1_code;
        wr_cmd.address     = r_s1_entry_address;
        wr_cmd.mask        = r_s1_mask;
        wr_cmd.range_low   = r_s1_range_low;
        wr_cmd.range_high  = r_s1_range_high;
        key.code           = r_s1_code;
        key.address        = r_s1_dst_address;
        key.port           = r_s1_dest_port;
    end

    fmprc_rule_table #(
        .RULES           (RULES),
        .PROTOS_PER_RULE (PROTOS_PER_RULE),
        .ADDRS_PER_RULE  (ADDRS_PER_RULE),
        .PORTS_PER_RULE  (PORTS_PER_RULE)
    ) u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr_cmd),
        .i_key   (key),
        .o_match (match_vec)
    );

    // only lookups continue past stage 1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (en_s2) begin
            r_s2_v <= r_s1_v && (r_s1_mode == MODE_LOOKUP);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_s2) begin
            r_s2_match <= match_vec;
        end
    end

    // lowest set bit, then OR its index together (low 4 bits of the rule)
    assign first_bit = r_s2_match & (~r_s2_match + RULES'(1));

    always_comb begin
        n_rule = '0;
        for (int k = 0; k < RULES; k++) begin
            if (first_bit[k]) begin
                n_rule = n_rule | RULE_IDX_W'(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (en_out) begin
            r_o_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out && r_s2_v) begin
            r_o_hit  <= |r_s2_match;
            r_o_rule <= n_rule;
        end
    end

    assign o_valid        = r_o_v;
    assign o_hit          = r_o_hit;
    assign o_matched_rule = r_o_rule;

endmodule

`default_nettype wire
